>>> hw/rtl/crcc_pkg.sv
// ----------------------------------------------------------------------------
// crcc_pkg
// Shared types, constants and polynomial tables for the selectable CRC checker.
// ----------------------------------------------------------------------------
package crcc_pkg;

	localparam int CRC_W = 24;
	localparam int LEN_W = 5;
	localparam int CNT_W = 11;
	localparam int SEL_W = 3;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W = 1;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_POLY_SELECT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'd1;

	// polynomial selector codes
	localparam logic [SEL_W-1:0] SEL_CRC24A = 3'd0;
	localparam logic [SEL_W-1:0] SEL_CRC24B = 3'd1;
	localparam logic [SEL_W-1:0] SEL_CRC24C = 3'd2;
	localparam logic [SEL_W-1:0] SEL_CRC16  = 3'd3;
	localparam logic [SEL_W-1:0] SEL_CRC11  = 3'd4;
	localparam logic [SEL_W-1:0] SEL_CRC6   = 3'd5;

	localparam logic [SEL_W-1:0] POLY_SELECT_RST  = SEL_CRC24A;
	localparam logic [CNT_W-1:0] BLOCK_LENGTH_RST = 11'd64;

	// control broadcast to every remainder cell
	typedef struct packed {
		logic en;   // request accepted this cycle
		logic clr;  // codeword ends, clear after this bit
		logic fb;   // reduction feedback (top remainder bit)
	} cell_ctrl_t;

	// per-bit codeword position status
	typedef struct packed {
		logic payload;
		logic last;
	} blk_status_t;

	// generator without the leading term; out-of-range selectors act as crc6
	function automatic logic [CRC_W-1:0] gen_low(input logic [SEL_W-1:0] sel);
		logic [CRC_W-1:0] g;
		case (sel)
			SEL_CRC24A: g = 24'h864CFB;
			SEL_CRC24B: g = 24'h800063;
			SEL_CRC24C: g = 24'hB2B117;
			SEL_CRC16:  g = 24'h001021;
			SEL_CRC11:  g = 24'h000621;
			default:    g = 24'h000021;
		endcase
		return g;
	endfunction

	function automatic logic [LEN_W-1:0] gen_len(input logic [SEL_W-1:0] sel);
		logic [LEN_W-1:0] l;
		case (sel)
			SEL_CRC24A, SEL_CRC24B, SEL_CRC24C: l = 5'd24;
			SEL_CRC16:  l = 5'd16;
			SEL_CRC11:  l = 5'd11;
			default:    l = 5'd6;
		endcase
		return l;
	endfunction

endpackage

>>> hw/rtl/crcc_if.sv
// ----------------------------------------------------------------------------
// crcc_if
// Valid/ready channels for codeword bits in and check results out.
// ----------------------------------------------------------------------------
interface crcc_in_if;
	logic valid;
	logic ready;
	logic data_bit;

	modport source (output valid, output data_bit, input ready);
	modport sink (input valid, input data_bit, output ready);
endinterface

interface crcc_out_if;
	logic valid;
	logic ready;
	logic payload_bit;
	logic is_payload;
	logic block_end;
	logic crc_error;

	modport source (output valid, output payload_bit, output is_payload,
		output block_end, output crc_error, input ready);
	modport sink (input valid, input payload_bit, input is_payload,
		input block_end, input crc_error, output ready);
endinterface

>>> hw/rtl/crcc_cell.sv
// ----------------------------------------------------------------------------
// crcc_cell
// One bit of the GF(2) remainder shift register with conditional reduction.
// ----------------------------------------------------------------------------
module crcc_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crcc_pkg::cell_ctrl_t ctl,
	input  logic                 active,
	input  logic                 gen_bit,
	input  logic                 shift_in,
	output logic                 nxt,
	output logic                 q
);

	logic bit_q;

	// positions above the crc length are held at zero
	assign nxt = active & (shift_in ^ (ctl.fb & gen_bit));
	assign q   = bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctl.en) begin
			bit_q <= ctl.clr ? 1'b0 : nxt;
		end
	end

endmodule

>>> hw/rtl/crcc_ctrl.sv
// ----------------------------------------------------------------------------
// crcc_ctrl
// Bit counter within the codeword; flags payload bits and the last bit.
// ----------------------------------------------------------------------------
module crcc_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [crcc_pkg::SEL_W-1:0]          poly_select,
	input  logic [crcc_pkg::CNT_W-1:0]          block_length,
	output crcc_pkg::blk_status_t               status
);

	logic [crcc_pkg::CNT_W-1:0] cnt_q;
	logic [crcc_pkg::LEN_W-1:0] len;
	logic [crcc_pkg::CNT_W-1:0] blen;
	logic [crcc_pkg::CNT_W-1:0] len_ext;
	logic [crcc_pkg::CNT_W:0]   cnt_inc;

	assign len     = crcc_pkg::gen_len(poly_select);
	assign len_ext = {{(crcc_pkg::CNT_W-crcc_pkg::LEN_W){1'b0}}, len};
	// zero length behaves like one
	assign blen    = (block_length == '0) ? {{(crcc_pkg::CNT_W-1){1'b0}}, 1'b1} : block_length;
	assign cnt_inc = {1'b0, cnt_q} + {{crcc_pkg::CNT_W{1'b0}}, 1'b1};

	assign status.payload = (blen > len_ext) && (cnt_q < (blen - len_ext));
	assign status.last    = cnt_inc >= {1'b0, blen};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= status.last ? '0 : cnt_inc[crcc_pkg::CNT_W-1:0];
		end
	end

endmodule

>>> hw/rtl/crc_check_selectable_poly.sv
// ----------------------------------------------------------------------------
// crc_check_selectable_poly
// Serial checker for codewords protected by a selectable 5G NR CRC.
// ----------------------------------------------------------------------------
// The block takes one codeword bit per request, most significant bit first,
// and returns one result per request: the bit itself, a payload flag for bits
// ahead of the crc field, a block-end flag on the last bit and, on that last
// bit only, a crc error flag that is set when the remainder is nonzero. It
// accepts a new bit in every cycle as long as the result register is empty
// or being drained in the same cycle.
// The remainder lives in a row of 24 one-bit cells, each shifting into its
// upper neighbor and xoring in the shared feedback; that single shift-and-xor
// step per cycle sets the rate. poly_select picks crc24a/b/c, crc16, crc11 or
// crc6 (codes 6 and 7 act as crc6) and block_length gives the codeword size
// including the crc bits (0 acts as 1). Configuration writes take effect on
// the next bit and leave the remainder and bit counter alone; the counter and
// remainder clear themselves after each block end.
// ----------------------------------------------------------------------------
module crc_check_selectable_poly (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [crcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crcc_pkg::CFG_DATA_W-1:0]    cfg_data,
	crcc_in_if.sink                            codeword,
	crcc_out_if.source                         result
);

	// configuration registers
	logic [crcc_pkg::SEL_W-1:0] poly_select_q;
	logic [crcc_pkg::CNT_W-1:0] block_length_q;

	// selector after saturation, and the derived polynomial
	logic [crcc_pkg::SEL_W-1:0] sel;
	logic [crcc_pkg::LEN_W-1:0] len;
	logic [crcc_pkg::LEN_W-1:0] fb_idx;
	logic [crcc_pkg::CRC_W-1:0] gen;

	// remainder row
	logic [crcc_pkg::CRC_W-1:0] rem;
	logic [crcc_pkg::CRC_W-1:0] rem_nxt;
	logic [crcc_pkg::CRC_W-1:0] active;
	crcc_pkg::cell_ctrl_t       cell_ctl;
	crcc_pkg::blk_status_t      status;

	// request handshake
	logic accept;

	// result register
	logic out_valid_q;
	logic bit_q;
	logic pay_q;
	logic end_q;
	logic err_q;

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_select_q  <= crcc_pkg::POLY_SELECT_RST;
			block_length_q <= crcc_pkg::BLOCK_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crcc_pkg::REG_POLY_SELECT:  poly_select_q  <= cfg_data[crcc_pkg::SEL_W-1:0];
				crcc_pkg::REG_BLOCK_LENGTH: block_length_q <= cfg_data[crcc_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign sel    = (poly_select_q > crcc_pkg::SEL_CRC6) ? crcc_pkg::SEL_CRC6 : poly_select_q;
	assign len    = crcc_pkg::gen_len(sel);
	assign gen    = crcc_pkg::gen_low(sel);
	assign fb_idx = len - 5'd1;

	// take a new bit whenever the result slot is free or freeing up
	assign codeword.ready = !out_valid_q || result.ready;
	assign accept         = codeword.valid && codeword.ready;

	crcc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.poly_select  (sel),
		.block_length (block_length_q),
		.status       (status)
	);

	// feedback comes from the top bit of the current crc length; bits above it
	// may still be set after a selector change and are masked out here
	assign cell_ctl.en  = accept;
	assign cell_ctl.clr = status.last;
	assign cell_ctl.fb  = rem[fb_idx];

	genvar gi;
	generate
		for (gi = 0; gi < crcc_pkg::CRC_W; gi++) begin : g_cell
			logic shift_in;

			assign active[gi] = 5'(gi) < len;

			if (gi == 0) begin : g_first
				assign shift_in = codeword.data_bit;
			end else begin : g_rest
				assign shift_in = rem[gi-1];
			end

			crcc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (cell_ctl),
				.active   (active[gi]),
				.gen_bit  (gen[gi]),
				.shift_in (shift_in),
				.nxt      (rem_nxt[gi]),
				.q        (rem[gi])
			);
		end
	endgenerate

	// result register: valid under reset, fields load on each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bit_q <= codeword.data_bit;
			pay_q <= status.payload;
			end_q <= status.last;
			// error only reported on the closing bit
			err_q <= status.last && (rem_nxt != '0);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.payload_bit = bit_q;
	assign result.is_payload  = pay_q;
	assign result.block_end   = end_q;
	assign result.crc_error   = err_q;

	// remainder is cleared after every block end
	a_clear_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status.last |=> rem == '0)
		else $error("remainder not cleared after block end");

	// an accepted bit always shows up in the result register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted bit produced no result");

	// error flag only ever accompanies a block end
	a_err_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && err_q |-> end_q)
		else $error("crc error outside block end");

	// a payload bit can never be the last bit of a codeword
	a_payload_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pay_q |-> !end_q)
		else $error("payload bit flagged as block end");

endmodule

>>> test/crc_check_selectable_poly_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_check_selectable_poly_tb
// Self-checking bench for the serial 5G NR crc checker.
// ----------------------------------------------------------------------------
// Bits are sent one per request with random gaps, and results are taken with
// random stalls. A bit-accurate tracker of the remainder, the bit counter and
// both registers predicts every result. Most random stimulus is codewords
// that carry a correct crc, so both outcomes of the check are seen; the rest
// is codewords with one bit flipped, pure noise and cut-off codewords.
// Registers are only rewritten while no result is outstanding, and this
// includes points in the middle of a codeword.
// ----------------------------------------------------------------------------
module crc_check_selectable_poly_tb;

	// kinds of codeword that the generator can build
	typedef enum int {CLEAN, ONE_FLIPPED, NOISE} flaw_t;

	// one result as seen on the output channel
	typedef struct packed {
		logic payload_bit;
		logic is_payload;
		logic block_end;
		logic crc_error;
	} bit_flags_t;

	// generator taps without the leading term, with the crc width
	typedef struct packed {
		logic [crcc_pkg::LEN_W-1:0] w;
		logic [crcc_pkg::CRC_W-1:0] taps;
	} poly_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [crcc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [crcc_pkg::CFG_DATA_W-1:0] cfg_data;

	crcc_in_if cw_if ();
	crcc_out_if res_if ();

	crc_check_selectable_poly dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.codeword  (cw_if),
		.result    (res_if)
	);

	// 4 ns clock
	always #2 clk = ~clk;

	// tracked copy of the block: registers first, then the running state
	logic [crcc_pkg::SEL_W-1:0] cur_sel = crcc_pkg::POLY_SELECT_RST;
	logic [crcc_pkg::CNT_W-1:0] cur_len = crcc_pkg::BLOCK_LENGTH_RST;
	logic [crcc_pkg::CNT_W-1:0] rx_count = '0;
	logic [crcc_pkg::CRC_W-1:0] rx_rem = '0;

	// predicted results, oldest first
	bit_flags_t expected_flags[$];

	int fail_count = 0;
	int results_seen = 0;
	int bits_sent = 0;

	// sender pacing: runs of zero-gap requests and runs of random gaps, picked at random
	int send_left = 0;
	bit send_calm = 1'b0;

	function automatic poly_t poly_of(input logic [crcc_pkg::SEL_W-1:0] sel);
		poly_t p;
		case (sel)
			crcc_pkg::SEL_CRC24A: p = '{5'd24, 24'h864CFB};
			crcc_pkg::SEL_CRC24B: p = '{5'd24, 24'h800063};
			crcc_pkg::SEL_CRC24C: p = '{5'd24, 24'hB2B117};
			crcc_pkg::SEL_CRC16:  p = '{5'd16, 24'h001021};
			crcc_pkg::SEL_CRC11:  p = '{5'd11, 24'h000621};
			// crc6, and the two unused codes fold onto it
			default:              p = '{5'd6, 24'h000021};
		endcase
		return p;
	endfunction

	// one step of the polynomial division: shift a bit in, reduce if the
	// bit at the degree position came up
	function automatic logic [crcc_pkg::CRC_W-1:0] shift_in(
		input logic [crcc_pkg::CRC_W-1:0] rem, input logic b, input poly_t p);
		logic [crcc_pkg::CRC_W:0] sh;
		logic [crcc_pkg::CRC_W-1:0] mask;
		mask = {crcc_pkg::CRC_W{1'b1}} >> (crcc_pkg::CRC_W - p.w);
		sh = {rem & mask, b};
		if (sh[p.w]) begin
			sh[crcc_pkg::CRC_W-1:0] = sh[crcc_pkg::CRC_W-1:0] ^ p.taps;
		end
		return sh[crcc_pkg::CRC_W-1:0] & mask;
	endfunction

	// advance the tracked state by one accepted bit and return its flags
	function automatic bit_flags_t track_bit(input logic b);
		poly_t p;
		int blen;
		int w;
		bit_flags_t f;
		logic last_bit;
		p = poly_of(cur_sel);
		w = p.w;
		// a zero length behaves as one
		blen = (cur_len == '0) ? 1 : int'(cur_len);
		f.payload_bit = b;
		f.is_payload = (blen > w) && (int'(rx_count) < blen - w);
		// a length lowered below the count ends the codeword right here
		last_bit = (int'(rx_count) + 1) >= blen;
		f.block_end = last_bit;
		rx_rem = shift_in(rx_rem, b, p);
		f.crc_error = 1'b0;
		if (last_bit) begin
			f.crc_error = (rx_rem != '0);
			rx_rem = '0;
			rx_count = '0;
		end else begin
			rx_count = rx_count + 1'b1;
		end
		return f;
	endfunction

	task automatic report_fail(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// register write; the task returns only after cfg_we has dropped, so back-to-back writes never collide
	task automatic write_reg(input logic [crcc_pkg::CFG_IDX_W-1:0] idx,
		input logic [crcc_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == crcc_pkg::REG_POLY_SELECT) begin
			cur_sel = val[crcc_pkg::SEL_W-1:0];
		end else begin
			cur_len = val[crcc_pkg::CNT_W-1:0];
		end
		@(posedge clk);
	endtask

	// one bit request; valid stays up when the next bit follows without gap
	task automatic send_bit(input logic b);
		int gap;
		if (send_left == 0) begin
			send_calm = ($urandom_range(0, 3) == 0);
			send_left = $urandom_range(10, 60);
		end
		send_left--;
		gap = send_calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			cw_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cw_if.valid <= 1'b1;
		cw_if.data_bit <= b;
		do @(posedge clk); while (!cw_if.ready);
		expected_flags.push_back(track_bit(b));
		bits_sent++;
	endtask

	// drop valid and let every outstanding result drain
	task automatic wait_idle();
		cw_if.valid <= 1'b0;
		do @(posedge clk); while (expected_flags.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	// pad out a codeword left open by a cut or a register change
	task automatic close_codeword();
		while (rx_count != '0) begin
			send_bit(1'($urandom_range(0, 1)));
		end
	endtask

	// build a codeword for the current settings; keep > 0 and below the length cuts it short
	task automatic send_codeword(input flaw_t flaw, input int keep);
		poly_t p;
		int blen;
		int npay;
		int n;
		int i;
		int flip_at;
		logic [crcc_pkg::CRC_W-1:0] acc;
		logic word[$];
		p = poly_of(cur_sel);
		blen = (cur_len == '0) ? 1 : int'(cur_len);
		npay = (blen > p.w) ? blen - p.w : 0;
		acc = '0;
		for (i = 0; i < npay; i++) begin
			word.push_back(1'($urandom_range(0, 1)));
			acc = shift_in(acc, word[i], p);
		end
		if (npay > 0) begin
			// crc is the remainder of payload times x^L
			for (i = 0; i < p.w; i++) begin
				acc = shift_in(acc, 1'b0, p);
			end
			for (i = p.w - 1; i >= 0; i--) begin
				word.push_back(acc[i]);
			end
		end else begin
			// too short for a payload: only all zeros divides evenly
			for (i = 0; i < blen; i++) begin
				word.push_back(1'b0);
			end
		end
		case (flaw)
			ONE_FLIPPED: begin
				flip_at = $urandom_range(0, blen - 1);
				word[flip_at] = ~word[flip_at];
			end
			NOISE: begin
				for (i = 0; i < blen; i++) begin
					word[i] = 1'($urandom_range(0, 1));
				end
			end
			default: begin
			end
		endcase
		n = (keep > 0 && keep < blen) ? keep : blen;
		for (i = 0; i < n; i++) begin
			send_bit(word[i]);
		end
	endtask

	// reset values, then a length lowered below the current count
	task automatic test_reset_and_cut();
		send_bit(1'b1);
		send_bit(1'b0);
		send_bit(1'b1);
		wait_idle();
		write_reg(crcc_pkg::REG_BLOCK_LENGTH, crcc_pkg::CFG_DATA_W'(2));
		send_bit(1'b0);
	endtask

	// zero length: every bit closes a codeword
	task automatic test_zero_length();
		wait_idle();
		write_reg(crcc_pkg::REG_BLOCK_LENGTH, '0);
		send_bit(1'b1);
		send_bit(1'b0);
	endtask

	// codeword no longer than the crc: never any payload
	task automatic test_short_block();
		wait_idle();
		write_reg(crcc_pkg::REG_POLY_SELECT, crcc_pkg::CFG_DATA_W'(crcc_pkg::SEL_CRC16));
		write_reg(crcc_pkg::REG_BLOCK_LENGTH, crcc_pkg::CFG_DATA_W'(3));
		send_bit(1'b1);
		send_bit(1'b1);
		send_bit(1'b1);
	endtask

	// selector code 7 with all upper data bits set must behave as crc6
	task automatic test_selector_saturation();
		wait_idle();
		write_reg(crcc_pkg::REG_POLY_SELECT, {crcc_pkg::CFG_DATA_W{1'b1}});
		write_reg(crcc_pkg::REG_BLOCK_LENGTH, crcc_pkg::CFG_DATA_W'(9));
		send_codeword(CLEAN, 0);
	endtask

	// polynomial switched halfway through a codeword
	task automatic test_selector_switch();
		wait_idle();
		write_reg(crcc_pkg::REG_POLY_SELECT, crcc_pkg::CFG_DATA_W'(crcc_pkg::SEL_CRC24B));
		write_reg(crcc_pkg::REG_BLOCK_LENGTH, crcc_pkg::CFG_DATA_W'(10));
		send_codeword(NOISE, 5);
		wait_idle();
		write_reg(crcc_pkg::REG_POLY_SELECT, crcc_pkg::CFG_DATA_W'(crcc_pkg::SEL_CRC11));
		close_codeword();
	endtask

	// phases of random settings, each with a handful of codewords
	task automatic test_random_codewords(input int count);
		int start;
		int phase;
		int pick;
		int blen;
		int n;
		int k;
		logic [crcc_pkg::SEL_W-1:0] sel;
		logic [crcc_pkg::CNT_W-1:0] len;
		flaw_t flaw;
		start = bits_sent;
		phase = 0;
		while (bits_sent - start < count) begin
			wait_idle();
			// walk through every selector code first, then pick at random
			sel = (phase < 8) ? crcc_pkg::SEL_W'(phase) :
				crcc_pkg::SEL_W'($urandom_range(0, 7));
			write_reg(crcc_pkg::REG_POLY_SELECT, {8'($urandom_range(0, 255)), sel});
			pick = $urandom_range(0, 15);
			if (pick == 0) begin
				len = '0;
			end else if (pick < 3) begin
				len = crcc_pkg::CNT_W'($urandom_range(41, 300));
			end else begin
				len = crcc_pkg::CNT_W'($urandom_range(1, 40));
			end
			write_reg(crcc_pkg::REG_BLOCK_LENGTH, len);
			// a codeword cut off in the last phase finishes under new settings
			close_codeword();
			n = $urandom_range(2, 5);
			for (k = 0; k < n; k++) begin
				pick = $urandom_range(0, 11);
				flaw = (pick < 7) ? CLEAN : (pick < 10) ? ONE_FLIPPED : NOISE;
				send_codeword(flaw, 0);
			end
			blen = (len == '0) ? 1 : int'(len);
			if (blen > 1 && $urandom_range(0, 4) == 0) begin
				send_codeword(CLEAN, $urandom_range(1, blen - 1));
			end
			phase++;
		end
	endtask

	// start of a codeword at the largest length, then the length is lowered
	// below the count so the next bit closes it
	task automatic test_longest_block();
		wait_idle();
		write_reg(crcc_pkg::REG_POLY_SELECT, crcc_pkg::CFG_DATA_W'(crcc_pkg::SEL_CRC24C));
		close_codeword();
		wait_idle();
		write_reg(crcc_pkg::REG_BLOCK_LENGTH, {crcc_pkg::CFG_DATA_W{1'b1}});
		send_codeword(CLEAN, 120);
		wait_idle();
		write_reg(crcc_pkg::REG_BLOCK_LENGTH, crcc_pkg::CFG_DATA_W'(100));
		close_codeword();
	endtask

	// result side: random stalls, and every accepted result is checked
	initial begin : result_side
		int stall;
		int left;
		bit calm;
		bit_flags_t want;
		res_if.ready = 1'b0;
		left = 0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				left = $urandom_range(10, 60);
			end
			left--;
			stall = calm ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			results_seen++;
			if (expected_flags.size() == 0) begin
				report_fail($sformatf("result %0d arrived with no request pending",
					results_seen));
			end else begin
				want = expected_flags.pop_front();
				if (res_if.payload_bit !== want.payload_bit ||
						res_if.is_payload !== want.is_payload ||
						res_if.block_end !== want.block_end ||
						res_if.crc_error !== want.crc_error) begin
					report_fail($sformatf({"result %0d: expected payload_bit %0b ",
						"is_payload %0b block_end %0b crc_error %0b, got %0b %0b %0b %0b"},
						results_seen, want.payload_bit, want.is_payload,
						want.block_end, want.crc_error, res_if.payload_bit,
						res_if.is_payload, res_if.block_end, res_if.crc_error));
				end
			end
		end
	end

	// guard against a hang
	initial begin
		#4_000_000;
		$display("crc_check_selectable_poly regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = crcc_pkg::REG_POLY_SELECT;
		cfg_data = '0;
		cw_if.valid = 1'b0;
		cw_if.data_bit = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_cut();
		test_zero_length();
		test_short_block();
		test_selector_saturation();
		test_selector_switch();
		test_random_codewords(850);
		test_longest_block();

		// let the last results drain, then idle before the verdict
		cw_if.valid <= 1'b0;
		while (expected_flags.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0 && expected_flags.size() == 0) begin
			$display("crc_check_selectable_poly regression: pass");
		end else begin
			$display("crc_check_selectable_poly regression: fail");
		end
		$finish;
	end

endmodule
